@@ rtl/bbmc_pkg.sv @@
package bbmc_pkg;

  // Request opcodes.
  localparam logic OP_TICK     = 1'b0;
  localparam logic OP_SET_MODE = 1'b1;

  // Mode codes. Codes five and up hold the drive.
  localparam logic [2:0] MODE_OFF    = 3'd0;
  localparam logic [2:0] MODE_ON     = 3'd1;
  localparam logic [2:0] MODE_SLOW   = 3'd2;
  localparam logic [2:0] MODE_NORMAL = 3'd3;
  localparam logic [2:0] MODE_FAST   = 3'd4;

  // Register indexes on the write port.
  localparam logic [2:0] REG_SLOW_ON    = 3'd0;
  localparam logic [2:0] REG_SLOW_OFF   = 3'd1;
  localparam logic [2:0] REG_NORMAL_ON  = 3'd2;
  localparam logic [2:0] REG_NORMAL_OFF = 3'd3;
  localparam logic [2:0] REG_FAST_ON    = 3'd4;
  localparam logic [2:0] REG_FAST_OFF   = 3'd5;
  localparam logic [2:0] REG_INTENSITY  = 3'd6;

  localparam int MODE_W    = 3;
  localparam int WIDTH_W   = 11;
  localparam int ELAPSED_W = 17;
  localparam int DUR_W     = 16;
  localparam int PCT_W     = 8;
  localparam int WDATA_W   = 24;
  localparam int INDEX_W   = 3;

  localparam logic [WIDTH_W-1:0]   PW_MIN_US   = 11'd1000;
  localparam logic [WIDTH_W-1:0]   PW_MAX_US   = 11'd2000;
  localparam logic [PCT_W-1:0]     PCT_MAX     = 8'd100;
  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = 17'h1FFFF;

  // All configuration registers as seen by the core.
  typedef struct packed {
    logic [DUR_W-1:0] slow_on_ms;
    logic [DUR_W-1:0] slow_off_ms;
    logic [DUR_W-1:0] normal_on_ms;
    logic [DUR_W-1:0] normal_off_ms;
    logic [DUR_W-1:0] fast_on_ms;
    logic [DUR_W-1:0] fast_off_ms;
    logic [WDATA_W-1:0] blink_intensities;
  } cfg_regs_t;

  // Lit pulse width: percent clamped at 100, times ten, plus the minimum width.
  function automatic logic [WIDTH_W-1:0] lit_width(input logic [PCT_W-1:0] pct);
    logic [PCT_W-1:0] p;
    p = (pct > PCT_MAX) ? PCT_MAX : pct;
    return ({3'b000, p} << 3) + ({3'b000, p} << 1) + PW_MIN_US;
  endfunction

endpackage

@@ rtl/bbmc_cmd_if.sv @@
interface bbmc_cmd_if;
  import bbmc_pkg::*;

  logic              valid;
  logic              ready;
  logic              opcode;
  logic [MODE_W-1:0] new_mode;

  modport source (output valid, output opcode, output new_mode, input ready);
  modport sink   (input valid, input opcode, input new_mode, output ready);
endinterface

@@ rtl/bbmc_status_if.sv @@
interface bbmc_status_if;
  import bbmc_pkg::*;

  logic               valid;
  logic               ready;
  logic [WIDTH_W-1:0] pulse_width_us;
  logic               lamp_lit;

  modport source (output valid, output pulse_width_us, output lamp_lit, input ready);
  modport sink   (input valid, input pulse_width_us, input lamp_lit, output ready);
endinterface

@@ rtl/bbmc_cfg.sv @@
module bbmc_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          wr_en,
  input  logic [bbmc_pkg::INDEX_W-1:0]  wr_index,
  input  logic [bbmc_pkg::WDATA_W-1:0]  wr_data,
  output bbmc_pkg::cfg_regs_t           regs
);
  import bbmc_pkg::*;

  // Register file with reset values; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.slow_on_ms        <= 16'd1000;
      regs.slow_off_ms       <= 16'd1000;
      regs.normal_on_ms      <= 16'd500;
      regs.normal_off_ms     <= 16'd500;
      regs.fast_on_ms        <= 16'd200;
      regs.fast_off_ms       <= 16'd200;
      regs.blink_intensities <= 24'h646464;
    end else if (wr_en) begin
      case (wr_index)
        REG_SLOW_ON:    regs.slow_on_ms        <= wr_data[DUR_W-1:0];
        REG_SLOW_OFF:   regs.slow_off_ms       <= wr_data[DUR_W-1:0];
        REG_NORMAL_ON:  regs.normal_on_ms      <= wr_data[DUR_W-1:0];
        REG_NORMAL_OFF: regs.normal_off_ms     <= wr_data[DUR_W-1:0];
        REG_FAST_ON:    regs.fast_on_ms        <= wr_data[DUR_W-1:0];
        REG_FAST_OFF:   regs.fast_off_ms       <= wr_data[DUR_W-1:0];
        REG_INTENSITY:  regs.blink_intensities <= wr_data;
        default: ;
      endcase
    end
  end
endmodule

@@ rtl/bbmc_core.sv @@
module bbmc_core (
  input  logic                 clk,
  input  logic                 rst,
  input  bbmc_pkg::cfg_regs_t  regs,
  bbmc_cmd_if.sink             cmd,
  bbmc_status_if.source        status
);
  import bbmc_pkg::*;

  logic [MODE_W-1:0]    current_mode, current_mode_next;
  logic                 mode_changed, mode_changed_next;
  logic                 lit_flag, lit_flag_next;
  logic [ELAPSED_W-1:0] elapsed_ms, elapsed_ms_next;
  logic [WIDTH_W-1:0]   drive_width, drive_width_next;
  logic                 out_valid;
  logic                 accept;

  logic [DUR_W-1:0]     on_ms, off_ms;
  logic [PCT_W-1:0]     pct;
  logic [ELAPSED_W-1:0] elapsed_inc;
  logic                 is_blink;

  // A new request is taken while the result slot is empty or being drained.
  assign cmd.ready = !out_valid || status.ready;
  assign accept    = cmd.valid && cmd.ready;

  // The result is the state left by the last request.
  assign status.valid          = out_valid;
  assign status.pulse_width_us = drive_width;
  assign status.lamp_lit       = lit_flag;

  // Timing and intensity for the blink mode in force.
  always_comb begin
    on_ms    = regs.slow_on_ms;
    off_ms   = regs.slow_off_ms;
    pct      = regs.blink_intensities[7:0];
    is_blink = 1'b0;
    case (current_mode)
      MODE_SLOW: begin
        is_blink = 1'b1;
      end
      MODE_NORMAL: begin
        on_ms    = regs.normal_on_ms;
        off_ms   = regs.normal_off_ms;
        pct      = regs.blink_intensities[15:8];
        is_blink = 1'b1;
      end
      MODE_FAST: begin
        on_ms    = regs.fast_on_ms;
        off_ms   = regs.fast_off_ms;
        pct      = regs.blink_intensities[23:16];
        is_blink = 1'b1;
      end
      default: ;
    endcase
  end

  assign elapsed_inc = (elapsed_ms < ELAPSED_MAX) ? elapsed_ms + 1'b1 : elapsed_ms;

  // Next state for one request.
  always_comb begin
    current_mode_next = current_mode;
    mode_changed_next = mode_changed;
    lit_flag_next     = lit_flag;
    elapsed_ms_next   = elapsed_ms;
    drive_width_next  = drive_width;
    if (cmd.opcode == OP_SET_MODE) begin
      if (cmd.new_mode != current_mode) begin
        mode_changed_next = 1'b1;
        current_mode_next = cmd.new_mode;
      end
    end else begin
      elapsed_ms_next = elapsed_inc;
      if (current_mode == MODE_OFF) begin
        lit_flag_next    = 1'b0;
        drive_width_next = PW_MIN_US;
      end else if (current_mode == MODE_ON) begin
        lit_flag_next    = 1'b1;
        drive_width_next = PW_MAX_US;
      end else if (is_blink) begin
        if (mode_changed || (!lit_flag && elapsed_inc > {1'b0, off_ms})) begin
          mode_changed_next = 1'b0;
          lit_flag_next     = 1'b1;
          drive_width_next  = lit_width(pct);
          elapsed_ms_next   = '0;
        end else if (lit_flag && elapsed_inc > {1'b0, on_ms}) begin
          lit_flag_next    = 1'b0;
          drive_width_next = PW_MIN_US;
          elapsed_ms_next  = '0;
        end
      end
    end
  end

  // State and result valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      current_mode <= MODE_OFF;
      mode_changed <= 1'b0;
      lit_flag     <= 1'b0;
      elapsed_ms   <= '0;
      drive_width  <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (accept) begin
        current_mode <= current_mode_next;
        mode_changed <= mode_changed_next;
        lit_flag     <= lit_flag_next;
        elapsed_ms   <= elapsed_ms_next;
        drive_width  <= drive_width_next;
        out_valid    <= 1'b1;
      end else if (status.ready) begin
        out_valid <= 1'b0;
      end
    end
  end
endmodule

@@ rtl/beacon_blink_mode_controller.sv @@
// Channel   Role    Payload
// cmd       sink    opcode (tick or set mode), new_mode
// status    source  pulse_width_us, lamp_lit
// wr_*      write   wr_en, wr_index, wr_data (no read-back)
//
// One request per cycle while the result is not stalled; each yields its result in the cycle after acceptance.
// The mode state and drive registers are updated in a single pass and are
// presented directly as the result.
// A stalled result holds cmd.ready low; a draining result lets the next
// request in on the same edge. Synchronous reset restores all registers.
module beacon_blink_mode_controller (
  input  logic                          clk,
  input  logic                          rst,
  bbmc_cmd_if.sink                      cmd,
  bbmc_status_if.source                 status,
  input  logic                          wr_en,
  input  logic [bbmc_pkg::INDEX_W-1:0]  wr_index,
  input  logic [bbmc_pkg::WDATA_W-1:0]  wr_data
);
  import bbmc_pkg::*;

  cfg_regs_t regs;

  // Configuration registers.
  bbmc_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .regs     (regs)
  );

  // Mode and blink engine.
  bbmc_core u_core (
    .clk    (clk),
    .rst    (rst),
    .regs   (regs),
    .cmd    (cmd),
    .status (status)
  );
endmodule

@@ dv/tb.sv @@
`timescale 1ns / 1ps

module tb;
  import bbmc_pkg::*;

  // Mode codes without a name in the package. All of them hold the drive.
  localparam logic [MODE_W-1:0] MODE_FAULT_ONE = 3'd5;
  localparam logic [MODE_W-1:0] MODE_FAULT_TWO = 3'd6;
  localparam logic [MODE_W-1:0] MODE_SPARE     = 3'd7;

  // Index past the last register; a write there must change nothing.
  localparam logic [INDEX_W-1:0] REG_SPARE = 3'd7;

  localparam int unsigned STALL_LIMIT = 1000;
  localparam int unsigned RUN_CAP     = 300;
  localparam int unsigned LONG_RUN    = 63;

  typedef struct packed {
    logic [WIDTH_W-1:0] pulse_width_us;
    logic               lamp_lit;
  } beacon_status_t;

  typedef struct {
    logic              opcode;
    logic [MODE_W-1:0] new_mode;
    bit                fixed;
    beacon_status_t    status;
  } beacon_row_t;

  logic               clk;
  logic               rst;
  logic               wr_en;
  logic [INDEX_W-1:0] wr_index;
  logic [WDATA_W-1:0] wr_data;

  bbmc_cmd_if    cmd_ch ();
  bbmc_status_if status_ch ();

  beacon_blink_mode_controller DUT (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd_ch),
    .status   (status_ch),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data)
  );

  // Shadow copy of the registers and the blink state.
  cfg_regs_t            shadow_cfg;
  logic [MODE_W-1:0]    beacon_mode;
  logic                 change_pending;
  logic                 lamp_on;
  logic [ELAPSED_W-1:0] elapsed_cnt;
  logic [WIDTH_W-1:0]   drive_us;

  beacon_status_t expected_status[$];
  int unsigned    error_count;
  int unsigned    quiet_cycles;
  bit             no_gaps;

  // Directed requests at the reset settings, where every intensity is 100 percent.
  beacon_row_t directed_rows [26] = '{
    '{OP_SET_MODE, MODE_OFF,       1'b1, '{11'd0, 1'b0}},
    '{OP_TICK,     MODE_SPARE,     1'b1, '{PW_MIN_US, 1'b0}},
    '{OP_SET_MODE, MODE_ON,        1'b1, '{PW_MIN_US, 1'b0}},
    '{OP_TICK,     MODE_OFF,       1'b1, '{PW_MAX_US, 1'b1}},
    '{OP_TICK,     MODE_FAST,      1'b1, '{PW_MAX_US, 1'b1}},
    '{OP_SET_MODE, MODE_SPARE,     1'b1, '{PW_MAX_US, 1'b1}},
    '{OP_TICK,     MODE_OFF,       1'b1, '{PW_MAX_US, 1'b1}},
    '{OP_SET_MODE, MODE_FAULT_ONE, 1'b1, '{PW_MAX_US, 1'b1}},
    '{OP_TICK,     MODE_ON,        1'b1, '{PW_MAX_US, 1'b1}},
    '{OP_SET_MODE, MODE_OFF,       1'b1, '{PW_MAX_US, 1'b1}},
    '{OP_TICK,     MODE_SLOW,      1'b1, '{PW_MIN_US, 1'b0}},
    '{OP_SET_MODE, MODE_FAULT_TWO, 1'b1, '{PW_MIN_US, 1'b0}},
    '{OP_TICK,     MODE_NORMAL,    1'b1, '{PW_MIN_US, 1'b0}},
    '{OP_SET_MODE, MODE_SLOW,      1'b1, '{PW_MIN_US, 1'b0}},
    '{OP_TICK,     MODE_FAULT_TWO, 1'b1, '{PW_MAX_US, 1'b1}},
    '{OP_TICK,     MODE_SPARE,     1'b0, '0},
    '{OP_SET_MODE, MODE_NORMAL,    1'b0, '0},
    '{OP_TICK,     MODE_OFF,       1'b1, '{PW_MAX_US, 1'b1}},
    '{OP_SET_MODE, MODE_FAST,      1'b0, '0},
    '{OP_SET_MODE, MODE_FAST,      1'b0, '0},
    '{OP_TICK,     MODE_FAULT_ONE, 1'b1, '{PW_MAX_US, 1'b1}},
    '{OP_TICK,     MODE_ON,        1'b0, '0},
    '{OP_SET_MODE, MODE_OFF,       1'b0, '0},
    '{OP_TICK,     MODE_SPARE,     1'b1, '{PW_MIN_US, 1'b0}},
    '{OP_SET_MODE, MODE_SLOW,      1'b0, '0},
    '{OP_TICK,     MODE_SLOW,      1'b1, '{PW_MAX_US, 1'b1}}
  };

  // 20 ns clock.
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic void reset_beacon_model();
    shadow_cfg = '{slow_on_ms: 16'd1000, slow_off_ms: 16'd1000,
                   normal_on_ms: 16'd500, normal_off_ms: 16'd500,
                   fast_on_ms: 16'd200, fast_off_ms: 16'd200,
                   blink_intensities: 24'h646464};
    beacon_mode    = MODE_OFF;
    change_pending = 1'b0;
    lamp_on        = 1'b0;
    elapsed_cnt    = '0;
    drive_us       = '0;
  endfunction

  function automatic void apply_reg(input logic [INDEX_W-1:0] idx,
                                    input logic [WDATA_W-1:0] d);
    case (idx)
      REG_SLOW_ON:    shadow_cfg.slow_on_ms        = d[DUR_W-1:0];
      REG_SLOW_OFF:   shadow_cfg.slow_off_ms       = d[DUR_W-1:0];
      REG_NORMAL_ON:  shadow_cfg.normal_on_ms      = d[DUR_W-1:0];
      REG_NORMAL_OFF: shadow_cfg.normal_off_ms     = d[DUR_W-1:0];
      REG_FAST_ON:    shadow_cfg.fast_on_ms        = d[DUR_W-1:0];
      REG_FAST_OFF:   shadow_cfg.fast_off_ms       = d[DUR_W-1:0];
      REG_INTENSITY:  shadow_cfg.blink_intensities = d;
      default: ;
    endcase
  endfunction

  // Lit width in microseconds; percentages over 100 count as 100.
  function automatic logic [WIDTH_W-1:0] lit_drive(input logic [PCT_W-1:0] pct);
    logic [WIDTH_W-1:0] p;
    p = (pct > PCT_MAX) ? WIDTH_W'(PCT_MAX) : WIDTH_W'(pct);
    return p * 11'd10 + PW_MIN_US;
  endfunction

  // One tick of a blink mode: restart lit after a change, else toggle on timeout.
  function automatic void blink_phase(input logic [DUR_W-1:0] on_ms,
                                      input logic [DUR_W-1:0] off_ms,
                                      input logic [PCT_W-1:0] pct);
    if (change_pending) begin
      change_pending = 1'b0;
      lamp_on        = 1'b1;
      drive_us       = lit_drive(pct);
      elapsed_cnt    = '0;
    end else if (!lamp_on && elapsed_cnt > ELAPSED_W'(off_ms)) begin
      lamp_on     = 1'b1;
      drive_us    = lit_drive(pct);
      elapsed_cnt = '0;
    end else if (lamp_on && elapsed_cnt > ELAPSED_W'(on_ms)) begin
      lamp_on     = 1'b0;
      drive_us    = PW_MIN_US;
      elapsed_cnt = '0;
    end
  endfunction

  // Advances the shadow state by one request and returns the status it yields.
  function automatic beacon_status_t predict_status(input logic op,
                                                    input logic [MODE_W-1:0] m);
    if (op == OP_SET_MODE) begin
      if (m != beacon_mode) begin
        change_pending = 1'b1;
        beacon_mode    = m;
      end
    end else begin
      if (elapsed_cnt != ELAPSED_MAX) begin
        elapsed_cnt++;
      end
      case (beacon_mode)
        MODE_OFF: begin
          lamp_on  = 1'b0;
          drive_us = PW_MIN_US;
        end
        MODE_ON: begin
          lamp_on  = 1'b1;
          drive_us = PW_MAX_US;
        end
        MODE_SLOW: begin
          blink_phase(shadow_cfg.slow_on_ms, shadow_cfg.slow_off_ms,
                      shadow_cfg.blink_intensities[7:0]);
        end
        MODE_NORMAL: begin
          blink_phase(shadow_cfg.normal_on_ms, shadow_cfg.normal_off_ms,
                      shadow_cfg.blink_intensities[15:8]);
        end
        MODE_FAST: begin
          blink_phase(shadow_cfg.fast_on_ms, shadow_cfg.fast_off_ms,
                      shadow_cfg.blink_intensities[23:16]);
        end
        // Fault codes hold drive, lit flag and change mark.
        default: ;
      endcase
    end
    return '{pulse_width_us: drive_us, lamp_lit: lamp_on};
  endfunction

  // Blink modes most of the time, any code otherwise.
  function automatic logic [MODE_W-1:0] pick_mode();
    if ($urandom_range(99) < 70) begin
      return MODE_W'($urandom_range(MODE_FAST, MODE_SLOW));
    end
    return MODE_W'($urandom_range(MODE_SPARE, MODE_OFF));
  endfunction

  function automatic int unsigned longer_of(input logic [DUR_W-1:0] a,
                                            input logic [DUR_W-1:0] b);
    return (a > b) ? int'(a) : int'(b);
  endfunction

  // Longest tick run for a mode: twice its longer phase plus four, capped at RUN_CAP.
  function automatic int unsigned run_span(input logic [MODE_W-1:0] m);
    int unsigned longest;
    int unsigned span;
    case (m)
      MODE_SLOW:   longest = longer_of(shadow_cfg.slow_on_ms, shadow_cfg.slow_off_ms);
      MODE_NORMAL: longest = longer_of(shadow_cfg.normal_on_ms, shadow_cfg.normal_off_ms);
      MODE_FAST:   longest = longer_of(shadow_cfg.fast_on_ms, shadow_cfg.fast_off_ms);
      default:     longest = 4;
    endcase
    span = 2 * longest + 4;
    return (span > RUN_CAP) ? RUN_CAP : span;
  endfunction

  function automatic cfg_regs_t random_settings(input int unsigned max_dur);
    cfg_regs_t s;
    s.slow_on_ms        = DUR_W'($urandom_range(max_dur));
    s.slow_off_ms       = DUR_W'($urandom_range(max_dur));
    s.normal_on_ms      = DUR_W'($urandom_range(max_dur));
    s.normal_off_ms     = DUR_W'($urandom_range(max_dur));
    s.fast_on_ms        = DUR_W'($urandom_range(max_dur));
    s.fast_off_ms       = DUR_W'($urandom_range(max_dur));
    s.blink_intensities = WDATA_W'($urandom);
    return s;
  endfunction

  // Duration written with random bits above the register width.
  function automatic logic [WDATA_W-1:0] pad_duration(input logic [DUR_W-1:0] v);
    return {8'($urandom_range(255)), v};
  endfunction

  // Presents one request, with random gaps ahead of it, and records its status.
  task automatic send_request(input logic op, input logic [MODE_W-1:0] m,
                              input bit fixed, input beacon_status_t typed);
    beacon_status_t pred;
    while (!no_gaps && $urandom_range(99) < 30) begin
      cmd_ch.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_ch.valid    <= 1'b1;
    cmd_ch.opcode   <= op;
    cmd_ch.new_mode <= m;
    do @(posedge clk); while (!cmd_ch.ready);
    pred = predict_status(op, m);
    expected_status.push_back(fixed ? typed : pred);
  endtask

  // The mode field of a tick is ignored, so it carries random bits.
  task automatic tick_run(input int unsigned n);
    repeat (n) begin
      send_request(OP_TICK, MODE_W'($urandom_range(MODE_SPARE)), 1'b0, '0);
    end
  endtask

  // Mostly a mode change followed by a run of ticks; the rest single random requests.
  task automatic random_traffic(input int unsigned n_items);
    int unsigned       sent;
    int unsigned       run;
    logic [MODE_W-1:0] m;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(99) < 80) begin
        m = pick_mode();
        send_request(OP_SET_MODE, m, 1'b0, '0);
        run = $urandom_range(run_span(m), 1);
        // Keep the block to its request count.
        if (run > n_items - sent - 1) begin
          run = n_items - sent - 1;
        end
        tick_run(run);
        sent += run + 1;
      end else begin
        send_request(1'($urandom_range(1)), MODE_W'($urandom_range(MODE_SPARE)),
                     1'b0, '0);
        sent++;
      end
    end
  endtask

  // Stops requests and waits until every status has come back.
  task automatic drain_status();
    cmd_ch.valid <= 1'b0;
    while (expected_status.size() != 0) @(posedge clk);
  endtask

  task automatic program_reg(input logic [INDEX_W-1:0] idx,
                             input logic [WDATA_W-1:0] d);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= d;
    @(posedge clk);
    apply_reg(idx, d);
  endtask

  // Rewrites every register while the block is idle, plus a write to the unused index.
  task automatic program_all(input cfg_regs_t t);
    drain_status();
    program_reg(REG_SLOW_ON,    pad_duration(t.slow_on_ms));
    program_reg(REG_SLOW_OFF,   pad_duration(t.slow_off_ms));
    program_reg(REG_NORMAL_ON,  pad_duration(t.normal_on_ms));
    program_reg(REG_NORMAL_OFF, pad_duration(t.normal_off_ms));
    program_reg(REG_FAST_ON,    pad_duration(t.fast_on_ms));
    program_reg(REG_FAST_OFF,   pad_duration(t.fast_off_ms));
    program_reg(REG_INTENSITY,  t.blink_intensities);
    program_reg(REG_SPARE,      WDATA_W'($urandom));
    wr_en <= 1'b0;
  endtask

  // Status sink: random back-pressure and comparison against the oldest expectation.
  always @(posedge clk) begin
    beacon_status_t want;
    if (rst) begin
      status_ch.ready <= 1'b0;
    end else begin
      if (status_ch.valid && status_ch.ready) begin
        if (expected_status.size() == 0) begin
          $error("status returned with no request outstanding");
          error_count++;
        end else begin
          want = expected_status.pop_front();
          if (status_ch.pulse_width_us !== want.pulse_width_us) begin
            $error("pulse_width_us: expected %0d, got %0d",
                   want.pulse_width_us, status_ch.pulse_width_us);
            error_count++;
          end
          if (status_ch.lamp_lit !== want.lamp_lit) begin
            $error("lamp_lit: expected %0b, got %0b", want.lamp_lit, status_ch.lamp_lit);
            error_count++;
          end
        end
      end
      status_ch.ready <= no_gaps || ($urandom_range(99) >= 30);
    end
  end

  // Watchdog on cycles without any handshake.
  always @(posedge clk) begin
    if (rst || (cmd_ch.valid && cmd_ch.ready) || (status_ch.valid && status_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("beacon_blink_mode_controller verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    cfg_regs_t s;
    rst             <= 1'b1;
    wr_en           <= 1'b0;
    wr_index        <= '0;
    wr_data         <= '0;
    cmd_ch.valid    <= 1'b0;
    cmd_ch.opcode   <= OP_TICK;
    cmd_ch.new_mode <= MODE_OFF;
    no_gaps         = 1'b0;
    error_count     = 0;
    reset_beacon_model();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed table at the reset settings, then random traffic on them.
    foreach (directed_rows[i]) begin
      send_request(directed_rows[i].opcode, directed_rows[i].new_mode,
                   directed_rows[i].fixed, directed_rows[i].status);
    end
    random_traffic(120);

    // Short durations and no gaps on either side.
    program_all(random_settings(6));
    no_gaps = 1'b1;
    random_traffic(200);
    no_gaps = 1'b0;

    // All durations zero and zero intensity: toggles on every tick, dark-level lit width.
    program_all('0);
    random_traffic(120);

    // Intensities at and over the clamp.
    s = random_settings(15);
    s.blink_intensities = {8'($urandom_range(255, 101)), 8'd100, 8'd101};
    program_all(s);
    random_traffic(200);

    // Longest slow phase: full intensity, still lit after a run of ticks.
    s = random_settings(10);
    s.slow_on_ms        = '1;
    s.slow_off_ms       = '1;
    s.blink_intensities = '1;
    program_all(s);
    send_request(OP_SET_MODE, MODE_SLOW, 1'b0, '0);
    tick_run(LONG_RUN);
    random_traffic(120);

    drain_status();
    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("beacon_blink_mode_controller verification clean");
    end else begin
      $display("beacon_blink_mode_controller verification failed");
    end
    $finish;
  end

endmodule
